// File: rtl/tbsh_pkg.sv
// shared types, field widths and codes for the bracketing table search block
// no dependencies
`default_nettype none

package tbsh_pkg;

    localparam int IDX_W = 10;   // entry index, window start, lower index, saved bracket
    localparam int LEN_W = 11;   // table length and window points
    localparam int CD_W  = 10;   // correlation distance
    localparam int CFG_W = 11;   // config write data, widest register
    localparam int POS_W = 14;   // signed search position, room for gallop overshoot

    typedef logic [1:0]              op_t;
    typedef logic [1:0]              cfg_idx_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [LEN_W-1:0]        len_t;
    typedef logic [CD_W-1:0]         cd_t;
    typedef logic signed [POS_W-1:0] pos_t;

    localparam op_t OP_WRITE  = 2'd0;
    localparam op_t OP_BISECT = 2'd1;
    localparam op_t OP_HUNT   = 2'd2;

    localparam cfg_idx_t CFG_TABLE_LENGTH = 2'd0;
    localparam cfg_idx_t CFG_WINDOW_POINTS = 2'd1;
    localparam cfg_idx_t CFG_CORR_DIST    = 2'd2;

    // finished search handed from the sequencer to the output stage
    typedef struct packed {
        logic valid;
        logic err;
        pos_t jl;
        idx_t sav;
    } done_t;

    function automatic pos_t idx_to_pos(input idx_t v);
        return $signed({{(POS_W-IDX_W){1'b0}}, v});
    endfunction

    function automatic pos_t len_to_pos(input len_t v);
        return $signed({{(POS_W-LEN_W){1'b0}}, v});
    endfunction

endpackage

`default_nettype wire

// File: rtl/tbsh_ifs.sv
// valid/ready channel interfaces: command in, search result out
// uses tbsh_pkg for field types
`default_nettype none

interface tbsh_cmd_if #(
    parameter int KEY_BITS = 32
);
    logic                       valid;
    logic                       ready;
    tbsh_pkg::op_t              opcode;
    tbsh_pkg::idx_t             entry_index;
    logic signed [KEY_BITS-1:0] key_value;

    modport source (output valid, output opcode, output entry_index, output key_value,
                    input ready);
    modport sink   (input valid, input opcode, input entry_index, input key_value,
                    output ready);
endinterface

interface tbsh_res_if;
    logic           valid;
    logic           ready;
    tbsh_pkg::idx_t window_start;
    tbsh_pkg::idx_t lower_index;
    logic           correlated;
    logic           size_error;

    modport source (output valid, output window_start, output lower_index,
                    output correlated, output size_error, input ready);
    modport sink   (input valid, input window_start, input lower_index,
                    input correlated, input size_error, output ready);
endinterface

`default_nettype wire

// File: rtl/tbsh_key_mem.sv
// key table memory: one write port, one read port with registered data
// no package dependencies
`default_nettype none

module tbsh_key_mem #(
    parameter int DEPTH    = 1024,
    parameter int KEY_BITS = 32,
    parameter int ADDR_W   = 10
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic signed [KEY_BITS-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    output logic signed [KEY_BITS-1:0]      rd_data
);

    logic signed [KEY_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/tbsh_search.sv
// search sequencer: one shared key comparator, gallop (hunt only) then bisection,
// one table read per cycle; depends on tbsh_pkg
`default_nettype none

module tbsh_search #(
    parameter int KEY_BITS = 32,
    parameter int ADDR_W   = 10
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       hunt,
    input  wire logic                       size_err,
    input  wire logic signed [KEY_BITS-1:0] key,
    input  wire tbsh_pkg::len_t             n,
    output logic [ADDR_W-1:0]               rd_addr,
    input  wire logic signed [KEY_BITS-1:0] rd_data,
    output logic                            idle,
    output tbsh_pkg::done_t                 done,
    input  wire logic                       done_take
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_K0   = 3'd1;
    localparam logic [2:0] S_KN   = 3'd2;
    localparam logic [2:0] S_HS   = 3'd3;
    localparam logic [2:0] S_UP   = 3'd4;
    localparam logic [2:0] S_DN   = 3'd5;
    localparam logic [2:0] S_BIS  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]                 state_reg, state_next;
    logic signed [KEY_BITS-1:0] key_reg, key_next;
    logic signed [KEY_BITS-1:0] key0_reg, key0_next;
    logic                       asc_reg, asc_next;
    logic                       hunt_reg, hunt_next;
    logic                       err_reg, err_next;
    tbsh_pkg::pos_t             jl_reg, jl_next;
    tbsh_pkg::pos_t             ju_reg, ju_next;
    tbsh_pkg::pos_t             jm_reg, jm_next;
    tbsh_pkg::pos_t             inc_reg, inc_next;
    tbsh_pkg::idx_t             sav_reg, sav_next;

    logic signed [KEY_BITS-1:0] cmp_a, cmp_b;
    logic                       ge, past;
    tbsh_pkg::pos_t             n_last, sav_pos, probe, t, inc2, bj, bu, jm;
    logic                       go_bis;

    // the one comparator: direction check in S_KN, key against probed entry elsewhere
    always_comb
    begin
        if (state_reg == S_KN)
        begin
            cmp_a = rd_data;
            cmp_b = key0_reg;
        end
        else
        begin
            cmp_a = key_reg;
            cmp_b = rd_data;
        end
        ge   = (cmp_a >= cmp_b);
        past = (ge == asc_reg);
    end

    always_comb
    begin
        n_last     = tbsh_pkg::len_to_pos(n) - tbsh_pkg::pos_t'(1);
        sav_pos    = tbsh_pkg::idx_to_pos(sav_reg);
        state_next = state_reg;
        key_next   = key_reg;
        key0_next  = key0_reg;
        asc_next   = asc_reg;
        hunt_next  = hunt_reg;
        err_next   = err_reg;
        jl_next    = jl_reg;
        ju_next    = ju_reg;
        jm_next    = jm_reg;
        inc_next   = inc_reg;
        sav_next   = sav_reg;
        probe      = jl_reg;
        go_bis     = 1'b0;
        bj         = jl_reg;
        bu         = ju_reg;
        inc2       = inc_reg <<< 1;
        t          = jl_reg;
        jm         = jl_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next  = key;
                    hunt_next = hunt;
                    err_next  = size_err;
                    probe     = '0;
                    state_next = size_err ? S_FIN : S_K0;
                end
            end
            S_K0:
            begin
                key0_next  = rd_data;
                probe      = n_last;
                state_next = S_KN;
            end
            S_KN:
            begin
                asc_next = ge;
                if (hunt_reg && (sav_pos <= n_last))
                begin
                    jl_next    = sav_pos;
                    inc_next   = tbsh_pkg::pos_t'(1);
                    probe      = sav_pos;
                    state_next = S_HS;
                end
                else
                begin
                    go_bis = 1'b1;
                    bj     = '0;
                    bu     = n_last;
                end
            end
            S_HS:
            begin
                if (past)
                begin
                    t = jl_reg + tbsh_pkg::pos_t'(1);
                    if (t >= n_last)
                    begin
                        go_bis = 1'b1;
                        bj     = jl_reg;
                        bu     = n_last;
                    end
                    else
                    begin
                        ju_next    = t;
                        probe      = t;
                        state_next = S_UP;
                    end
                end
                else
                begin
                    t = jl_reg - tbsh_pkg::pos_t'(1);
                    if (t <= 0)
                    begin
                        go_bis = 1'b1;
                        bj     = '0;
                        bu     = jl_reg;
                    end
                    else
                    begin
                        ju_next    = jl_reg;
                        jl_next    = t;
                        probe      = t;
                        state_next = S_DN;
                    end
                end
            end
            S_UP:
            begin
                // probed entry is ju
                if (!past)
                begin
                    go_bis = 1'b1;
                    bj     = jl_reg;
                    bu     = ju_reg;
                end
                else
                begin
                    t = ju_reg + inc2;
                    if (t >= n_last)
                    begin
                        go_bis = 1'b1;
                        bj     = ju_reg;
                        bu     = n_last;
                    end
                    else
                    begin
                        jl_next  = ju_reg;
                        ju_next  = t;
                        inc_next = inc2;
                        probe    = t;
                    end
                end
            end
            S_DN:
            begin
                // probed entry is jl
                if (past)
                begin
                    go_bis = 1'b1;
                    bj     = jl_reg;
                    bu     = ju_reg;
                end
                else
                begin
                    t = jl_reg - inc2;
                    if (t <= 0)
                    begin
                        go_bis = 1'b1;
                        bj     = '0;
                        bu     = jl_reg;
                    end
                    else
                    begin
                        ju_next  = jl_reg;
                        jl_next  = t;
                        inc_next = inc2;
                        probe    = t;
                    end
                end
            end
            S_BIS:
            begin
                go_bis = 1'b1;
                if (past)
                begin
                    bj = jm_reg;
                    bu = ju_reg;
                end
                else
                begin
                    bj = jl_reg;
                    bu = jm_reg;
                end
            end
            S_FIN:
            begin
                if (done_take)
                begin
                    if (!err_reg)
                    begin
                        sav_next = jl_reg[tbsh_pkg::IDX_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // common bisection step: narrow bracket or finish
        if (go_bis)
        begin
            jl_next = bj;
            ju_next = bu;
            jm      = (bj + bu) >>> 1;
            if ((bu - bj) > tbsh_pkg::pos_t'(1))
            begin
                jm_next    = jm;
                probe      = jm;
                state_next = S_BIS;
            end
            else
            begin
                state_next = S_FIN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sav_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sav_reg   <= sav_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        key0_reg <= key0_next;
        asc_reg  <= asc_next;
        hunt_reg <= hunt_next;
        err_reg  <= err_next;
        jl_reg   <= jl_next;
        ju_reg   <= ju_next;
        jm_reg   <= jm_next;
        inc_reg  <= inc_next;
    end

    assign rd_addr = ADDR_W'($unsigned(probe));
    assign idle    = (state_reg == S_IDLE);
    assign done    = '{valid: (state_reg == S_FIN), err: err_reg, jl: jl_reg, sav: sav_reg};

endmodule

`default_nettype wire

// File: rtl/table_bracket_search_hunt.sv
// Bracketing table search with hunt. A monotonic key table (ascending or
// descending) is loaded through the cmd channel with write commands; query
// commands return the lower bracket index, the clamped start of an m-point
// window and a correlated flag on the res channel. Both channels transfer
// when valid and ready are high together. Table length, window points and
// correlation distance are set through the plain config write port; the user
// writes them only while idle, which the block does not enforce. Writes and
// unused opcodes give no result. A query with a bad table or window size
// returns size_error with all other fields zero. One query at a time:
// cmd.ready is low while a search runs. A bisection query first reads the
// two end entries for the direction, then makes one probe per cycle (single
// read port of the key table), then loads the result register. A hunt query
// adds one probe per gallop step, the saved bracket included. The next command
// can be taken in the same cycle as the result appears; writes are taken back
// to back while no search runs.
// The result register holds while res.ready is low; the finished search waits
// in the sequencer, so one result can be pending while another completes.
// Reset clears the saved bracket to 0 and the registers to n = 2, m = 2,
// distance 1; table contents are undefined until written.
// Depends on tbsh_pkg, tbsh_ifs, tbsh_key_mem and tbsh_search.
`default_nettype none

module table_bracket_search_hunt #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS    = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    tbsh_cmd_if.sink                         cmd,
    tbsh_res_if.source                       res,
    input  wire logic                        cfg_wr_en,
    input  wire tbsh_pkg::cfg_idx_t          cfg_index,
    input  wire logic [tbsh_pkg::CFG_W-1:0]  cfg_wr_data
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMP_W  = (ADDR_W + 1 > tbsh_pkg::LEN_W) ? ADDR_W + 1 : tbsh_pkg::LEN_W;

    tbsh_pkg::len_t table_length_reg;
    tbsh_pkg::len_t window_points_reg;
    tbsh_pkg::cd_t  corr_dist_reg;

    logic                       cmd_xfer, is_query, size_err, mem_we;
    logic [ADDR_W-1:0]          rd_addr;
    logic signed [KEY_BITS-1:0] rd_data;
    logic                       srch_idle, done_take;
    tbsh_pkg::done_t            done;

    logic                       res_valid_reg;
    tbsh_pkg::idx_t             ws_reg, jl_out_reg;
    logic                       corr_reg, err_reg;

    tbsh_pkg::pos_t             half, lim, ws, diff;
    logic                       corr;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg  <= tbsh_pkg::len_t'(2);
            window_points_reg <= tbsh_pkg::len_t'(2);
            corr_dist_reg     <= tbsh_pkg::cd_t'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tbsh_pkg::CFG_TABLE_LENGTH:
                begin
                    table_length_reg <= cfg_wr_data;
                end
                tbsh_pkg::CFG_WINDOW_POINTS:
                begin
                    window_points_reg <= cfg_wr_data;
                end
                tbsh_pkg::CFG_CORR_DIST:
                begin
                    corr_dist_reg <= cfg_wr_data[tbsh_pkg::CD_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cmd.ready = srch_idle;
    assign cmd_xfer  = cmd.valid && cmd.ready;

    always_comb
    begin
        is_query = cmd.opcode inside {tbsh_pkg::OP_BISECT, tbsh_pkg::OP_HUNT};
        size_err = (table_length_reg < tbsh_pkg::len_t'(2))
                || (window_points_reg < tbsh_pkg::len_t'(2))
                || (window_points_reg > table_length_reg)
                || (CMP_W'(table_length_reg) > CMP_W'(TABLE_DEPTH));
        mem_we   = cmd_xfer && (cmd.opcode == tbsh_pkg::OP_WRITE)
                && (CMP_W'(cmd.entry_index) < CMP_W'(TABLE_DEPTH));
    end

    tbsh_key_mem #(
        .DEPTH    (TABLE_DEPTH),
        .KEY_BITS (KEY_BITS),
        .ADDR_W   (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (ADDR_W'(cmd.entry_index)),
        .wr_data (cmd.key_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tbsh_search #(
        .KEY_BITS (KEY_BITS),
        .ADDR_W   (ADDR_W)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd_xfer && is_query),
        .hunt      (cmd.opcode == tbsh_pkg::OP_HUNT),
        .size_err  (size_err),
        .key       (cmd.key_value),
        .n         (table_length_reg),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .idle      (srch_idle),
        .done      (done),
        .done_take (done_take)
    );

    // window start and correlation from the finished bracket
    always_comb
    begin
        half = tbsh_pkg::len_to_pos((window_points_reg - tbsh_pkg::len_t'(2)) >> 1);
        lim  = tbsh_pkg::len_to_pos(table_length_reg)
             - tbsh_pkg::len_to_pos(window_points_reg);
        ws   = done.jl - half;
        if (ws > lim)
        begin
            ws = lim;
        end
        if (ws < 0)
        begin
            ws = '0;
        end
        diff = done.jl - tbsh_pkg::idx_to_pos(done.sav);
        if (diff < 0)
        begin
            diff = -diff;
        end
        corr = (diff <= tbsh_pkg::idx_to_pos(corr_dist_reg));
    end

    assign done_take = done.valid && (!res_valid_reg || res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (done_take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_take)
        begin
            if (done.err)
            begin
                ws_reg     <= '0;
                jl_out_reg <= '0;
                corr_reg   <= 1'b0;
                err_reg    <= 1'b1;
            end
            else
            begin
                ws_reg     <= ws[tbsh_pkg::IDX_W-1:0];
                jl_out_reg <= done.jl[tbsh_pkg::IDX_W-1:0];
                corr_reg   <= corr;
                err_reg    <= 1'b0;
            end
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.window_start = ws_reg;
    assign res.lower_index  = jl_out_reg;
    assign res.correlated   = corr_reg;
    assign res.size_error   = err_reg;

endmodule

`default_nettype wire
